// ----- sv/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Depth, widths, opcodes, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int OUT_CNT_W = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Common width for comparing count against position, at least the output count width
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_OPEN,   // cell at 'at' loads value, cells above take from the left
        ACT_CLOSE   // every cell takes from the right
    } cell_act_t;

    typedef struct packed {
        cell_act_t                 act;
        logic [IDX_W-1:0]          at;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ----- sv/bdq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell: one storage cell of the deque chain
// Holds one word; holds, loads the request word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                              aclk,
    input  logic [bdq_pkg::IDX_W-1:0]         cell_idx,
    input  bdq_pkg::cell_ctrl_t               ctrl,
    input  logic signed [bdq_pkg::DATA_W-1:0] left_data,
    input  logic signed [bdq_pkg::DATA_W-1:0] right_data,
    output logic signed [bdq_pkg::DATA_W-1:0] data
);

    logic signed [bdq_pkg::DATA_W-1:0] data_reg;
    logic signed [bdq_pkg::DATA_W-1:0] data_next;

    // Pick the next word from the broadcast action and this cell's index
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.act)
            bdq_pkg::ACT_OPEN: begin
                if (cell_idx == ctrl.at) begin
                    data_next = ctrl.value;
                end else if (cell_idx > ctrl.at) begin
                    data_next = left_data;
                end
            end
            bdq_pkg::ACT_CLOSE: begin
                data_next = right_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/bounded_deque_with_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_insert: bounded deque with positional insert
// A chain of word cells with a shared control word; one result per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_opcode, s_value, s_position
//  m_      | out       | m_valid / m_ready  | m_popped_value, m_status, m_count
//
//  The cells shift or load at the accepting edge, and the result sits in
//  the output register from the next cycle.
//  One request per cycle is sustained while m_ready stays high; the output
//  register sets the rate, a new request is taken when it is empty or drains.
//  Reset (aresetn low, synchronous) empties the deque and the output register.
//  While a result stalls, s_ready is low and the cells hold.
// ----------------------------------------------------------------------------
module bounded_deque_with_insert (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_opcode,
    input  logic signed [bdq_pkg::DATA_W-1:0]   s_value,
    input  logic [bdq_pkg::POS_W-1:0]           s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bdq_pkg::DATA_W-1:0]   m_popped_value,
    output logic [1:0]                          m_status,
    output logic [bdq_pkg::OUT_CNT_W-1:0]       m_count
);

    localparam int D  = bdq_pkg::DEPTH;
    localparam int CW = bdq_pkg::CNT_W;
    localparam int MW = bdq_pkg::CMP_W;
    localparam int IW = bdq_pkg::IDX_W;

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               m_valid_reg;
    logic signed [bdq_pkg::DATA_W-1:0]  popped_reg;
    logic [1:0]                         status_reg;
    logic [bdq_pkg::OUT_CNT_W-1:0]      out_count_reg;

    logic signed [bdq_pkg::DATA_W-1:0]  cell_data [D];
    bdq_pkg::cell_ctrl_t                ctrl;
    logic                               accept;
    logic                               full;
    logic                               empty;
    logic [MW-1:0]                      count_ext;
    logic [MW-1:0]                      pos_ext;
    logic [MW-1:0]                      limit;
    logic [MW-1:0]                      ins_at;
    logic [MW-1:0]                      next_ext;
    logic [CW-1:0]                      last_idx;
    logic signed [bdq_pkg::DATA_W-1:0]  popped;
    logic [1:0]                         status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full      = (count_reg == CW'(D));
    assign empty     = (count_reg == '0);
    assign count_ext = MW'(count_reg);
    assign pos_ext   = MW'(s_position);
    assign limit     = (count_ext > MW'(1)) ? count_ext : MW'(1);
    assign last_idx  = count_reg - CW'(1);

    // Work out the position an insert lands at
    always_comb begin
        if (empty) begin
            ins_at = '0;
        end else if (pos_ext > MW'(1)) begin
            ins_at = pos_ext;
        end else begin
            ins_at = MW'(1);
        end
    end

    // Decode the request into a cell action, popped word, status and new count
    always_comb begin
        ctrl.act   = bdq_pkg::ACT_HOLD;
        ctrl.at    = '0;
        ctrl.value = s_value;
        popped     = '0;
        status     = bdq_pkg::ST_OK;
        count_next = count_reg;
        unique case (s_opcode)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_INSERT: begin
                if (full) begin
                    status = bdq_pkg::ST_FULL;
                end else if (s_opcode == bdq_pkg::OP_INSERT && pos_ext > limit) begin
                    status = bdq_pkg::ST_RANGE;
                end else begin
                    ctrl.act   = bdq_pkg::ACT_OPEN;
                    count_next = count_reg + CW'(1);
                    if (s_opcode == bdq_pkg::OP_PUSH_BACK) begin
                        ctrl.at = IW'(count_reg);
                    end else if (s_opcode == bdq_pkg::OP_INSERT) begin
                        ctrl.at = IW'(ins_at);
                    end
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    ctrl.act   = bdq_pkg::ACT_CLOSE;
                    popped     = cell_data[0];
                    count_next = count_reg - CW'(1);
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    popped     = cell_data[last_idx[IW-1:0]];
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                status = bdq_pkg::ST_OK;
            end
        endcase
        // Hold the cells unless the item is taken
        if (!accept) begin
            ctrl.act = bdq_pkg::ACT_HOLD;
        end
    end

    assign next_ext = MW'(count_next);

    // Build the cell chain
    for (genvar i = 0; i < D; i++) begin : g_cell
        logic signed [bdq_pkg::DATA_W-1:0] left_w;
        logic signed [bdq_pkg::DATA_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == D - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end
        bdq_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IW'(i)),
            .ctrl       (ctrl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );
    end

    // Advance the count and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            popped_reg    <= popped;
            status_reg    <= status;
            out_count_reg <= next_ext[bdq_pkg::OUT_CNT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = popped_reg;
    assign m_status       = status_reg;
    assign m_count        = out_count_reg;

endmodule

// ----- sv/bdq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker: port-level checks for the bounded deque
// Watches the two channels and the reported count and status.
// ----------------------------------------------------------------------------
module bdq_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [2:0]                          s_opcode,
    input  logic signed [bdq_pkg::DATA_W-1:0]   s_value,
    input  logic [bdq_pkg::POS_W-1:0]           s_position,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [bdq_pkg::DATA_W-1:0]   m_popped_value,
    input  logic [1:0]                          m_status,
    input  logic [bdq_pkg::OUT_CNT_W-1:0]       m_count
);

    localparam int OW = bdq_pkg::OUT_CNT_W;

    // Empty output register always takes a new item
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output register");

    // A pop on an empty deque reports nothing removed and a zero count
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == bdq_pkg::ST_EMPTY |-> m_popped_value == '0 && m_count == '0)
        else $error("empty status with nonzero value or count");

    // A full report shows a count of the full depth
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == bdq_pkg::ST_FULL |-> m_count == OW'(bdq_pkg::DEPTH))
        else $error("full status with wrong count");

    // Each accepted item yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_popped_value)
            && $stable(m_status) && $stable(m_count))
        else $error("stalled result changed");

endmodule

bind bounded_deque_with_insert bdq_checker u_bdq_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_deque_with_insert
// Feeds opcode/value/position items through a valid/ready driver, keeps a
// private copy of the deque to predict each popped word, status and count,
// and checks every result item in order. The bench runs three idle patterns
// and holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 290;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [2:0]                        opcode;
        logic signed [bdq_pkg::DATA_W-1:0] value;
        logic [bdq_pkg::POS_W-1:0]         position;
    } deque_req_t;

    typedef struct packed {
        logic signed [bdq_pkg::DATA_W-1:0] popped;
        logic [1:0]                        status;
        logic [bdq_pkg::OUT_CNT_W-1:0]     count;
    } deque_result_t;

    typedef enum {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED,
        BURST_NOISE
    } burst_kind_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [2:0]                        s_opcode = '0;
    logic signed [bdq_pkg::DATA_W-1:0] s_value = '0;
    logic [bdq_pkg::POS_W-1:0]         s_position = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [bdq_pkg::DATA_W-1:0] m_popped_value;
    logic [1:0]                        m_status;
    logic [bdq_pkg::OUT_CNT_W-1:0]     m_count;

    deque_req_t    pending_items[$];
    deque_result_t awaited_results[$];

    // Shadow deque used for prediction
    logic signed [bdq_pkg::DATA_W-1:0] shadow_words[bdq_pkg::DEPTH];
    int                                shadow_fill = 0;

    int   send_idle_pct = 9;
    int   recv_idle_pct = 63;
    int   bench_phase = 1;
    logic rx_hold = 1'b0;
    logic in_taken = 1'b0;
    int   queued_total = 0;
    int   accepted_total = 0;
    int   error_count = 0;

    bounded_deque_with_insert dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_count        (m_count)
    );

    always #1 aclk = ~aclk;

    // Advance the shadow deque by one request and return its result
    function automatic deque_result_t predict_deque_result(deque_req_t req);
        deque_result_t res;
        int            slot;
        int            limit;
        bit            store_it;
        res.popped = '0;
        res.status = bdq_pkg::ST_OK;
        store_it = 1'b0;
        slot = 0;
        case (req.opcode)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_INSERT: begin
                if (shadow_fill >= bdq_pkg::DEPTH) begin
                    res.status = bdq_pkg::ST_FULL;
                end else if (req.opcode == bdq_pkg::OP_PUSH_FRONT) begin
                    store_it = 1'b1;
                end else if (req.opcode == bdq_pkg::OP_PUSH_BACK) begin
                    slot = shadow_fill;
                    store_it = 1'b1;
                end else begin
                    limit = (shadow_fill > 1) ? shadow_fill : 1;
                    if (int'(req.position) > limit) begin
                        res.status = bdq_pkg::ST_RANGE;
                    end else begin
                        // insert lands after the front element unless the deque is empty
                        if (shadow_fill != 0)
                            slot = (req.position > 1) ? int'(req.position) : 1;
                        store_it = 1'b1;
                    end
                end
                if (store_it) begin
                    for (int i = shadow_fill; i > slot; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[slot] = req.value;
                    shadow_fill++;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    res.popped = shadow_words[0];
                    for (int i = 0; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_fill--;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (shadow_fill == 0) begin
                    res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    res.popped = shadow_words[shadow_fill-1];
                    shadow_fill--;
                end
            end
            default: begin
                // spare opcodes leave the deque alone
            end
        endcase
        res.count = shadow_fill[bdq_pkg::OUT_CNT_W-1:0];
        return res;
    endfunction

    // Mostly random words, with the extremes mixed in
    function automatic logic signed [bdq_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic deque_req_t random_request(burst_kind_t kind);
        deque_req_t req;
        int         roll;
        req.value = random_word();
        req.position = ($urandom_range(0, 7) == 0) ? bdq_pkg::POS_W'($urandom_range(0, 31))
                                                   : bdq_pkg::POS_W'($urandom_range(0, 16));
        roll = $urandom_range(0, 99);
        case (kind)
            BURST_FILL: begin
                if (roll < 30)      req.opcode = bdq_pkg::OP_PUSH_FRONT;
                else if (roll < 60) req.opcode = bdq_pkg::OP_PUSH_BACK;
                else if (roll < 90) req.opcode = bdq_pkg::OP_INSERT;
                else if (roll < 95) req.opcode = bdq_pkg::OP_POP_FRONT;
                else                req.opcode = bdq_pkg::OP_POP_BACK;
            end
            BURST_DRAIN: begin
                if (roll < 40)      req.opcode = bdq_pkg::OP_POP_FRONT;
                else if (roll < 80) req.opcode = bdq_pkg::OP_POP_BACK;
                else if (roll < 87) req.opcode = bdq_pkg::OP_PUSH_FRONT;
                else if (roll < 94) req.opcode = bdq_pkg::OP_PUSH_BACK;
                else                req.opcode = bdq_pkg::OP_INSERT;
            end
            BURST_MIXED: begin
                if (roll < 20)      req.opcode = bdq_pkg::OP_PUSH_FRONT;
                else if (roll < 40) req.opcode = bdq_pkg::OP_PUSH_BACK;
                else if (roll < 60) req.opcode = bdq_pkg::OP_INSERT;
                else if (roll < 80) req.opcode = bdq_pkg::OP_POP_FRONT;
                else                req.opcode = bdq_pkg::OP_POP_BACK;
            end
            default: begin
                // spare opcodes, out-of-range inserts and stray pops
                if (roll < 50) begin
                    req.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end else if (roll < 80) begin
                    req.opcode = bdq_pkg::OP_INSERT;
                    req.position = bdq_pkg::POS_W'($urandom_range(17, 31));
                end else begin
                    req.opcode = ($urandom_range(0, 1) == 0) ? bdq_pkg::OP_POP_FRONT
                                                             : bdq_pkg::OP_POP_BACK;
                end
            end
        endcase
        return req;
    endfunction

    task automatic add_item(input logic [2:0] op,
                            input logic signed [bdq_pkg::DATA_W-1:0] val,
                            input logic [bdq_pkg::POS_W-1:0] pos);
        deque_req_t req;
        req.opcode = op;
        req.value = val;
        req.position = pos;
        pending_items.push_back(req);
        queued_total++;
    endtask

    // Queue bursts of requests; spare opcodes do not count toward the target
    task automatic add_random_bursts(input int target);
        deque_req_t  req;
        burst_kind_t kind;
        int          made;
        int          roll;
        made = 0;
        while (made < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)      kind = BURST_FILL;
            else if (roll < 65) kind = BURST_DRAIN;
            else if (roll < 90) kind = BURST_MIXED;
            else                kind = BURST_NOISE;
            repeat ($urandom_range(4, 24)) begin
                req = random_request(kind);
                add_item(req.opcode, req.value, req.position);
                if (req.opcode <= bdq_pkg::OP_POP_BACK)
                    made++;
            end
        end
    endtask

    task automatic wait_for_driver_idle();
        while (pending_items.size() != 0)
            @(posedge aclk);
    endtask

    // Drive the input channel; hold an item until it is taken
    always @(negedge aclk) begin
        deque_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                s_valid <= 1'b1;
                s_opcode <= nxt.opcode;
                s_value <= nxt.value;
                s_position <= nxt.position;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Drive ready on the result channel
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check each result item, then predict for a newly taken request
    always @(posedge aclk) begin
        deque_req_t    req;
        deque_result_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result item with nothing awaited: popped_value %0d status %0d count %0d",
                       m_popped_value, m_status, m_count);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_popped_value !== want.popped) begin
                    $error("popped_value: expected %0d, actual %0d", want.popped, m_popped_value);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    error_count++;
                end
                if (m_count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, m_count);
                    error_count++;
                end
            end
        end
        if (in_taken) begin
            req.opcode = s_opcode;
            req.value = s_value;
            req.position = s_position;
            awaited_results.push_back(predict_deque_result(req));
            accepted_total++;
        end
    end

    // Hold the result side off for a long stretch so the input backs up
    initial begin
        wait (bench_phase == 3);
        repeat (20) @(posedge aclk);
        rx_hold = 1'b1;
        repeat (64) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        for (int i = 0; i < bdq_pkg::DEPTH; i++)
            shadow_words[i] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty pops, inserts on an empty deque, out-of-range inserts, extremes, spare opcodes
        add_item(bdq_pkg::OP_POP_FRONT, 32'sd0, 5'd0);
        add_item(bdq_pkg::OP_POP_BACK, 32'sd0, 5'd0);
        add_item(bdq_pkg::OP_INSERT, 32'sd5, 5'd2);
        add_item(bdq_pkg::OP_INSERT, 32'sd11, 5'd0);
        add_item(bdq_pkg::OP_POP_BACK, 32'sd0, 5'd0);
        add_item(bdq_pkg::OP_INSERT, 32'sd22, 5'd1);
        add_item(bdq_pkg::OP_INSERT, 32'sd33, 5'd0);
        add_item(bdq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff, 5'd0);
        add_item(bdq_pkg::OP_PUSH_BACK, 32'sh8000_0000, 5'd0);
        add_item(bdq_pkg::OP_INSERT, -32'sd1, 5'd4);
        add_item(bdq_pkg::OP_INSERT, 32'sd44, 5'd6);
        add_item(bdq_pkg::OP_INSERT, 32'sd55, 5'd31);
        add_item(bdq_pkg::OP_INSERT, 32'sd66, 5'd16);
        add_item(OP_SPARE_FIRST, '1, 5'd31);
        add_item(OP_SPARE_MID, 32'sd0, 5'd0);
        add_item(OP_SPARE_LAST, '1, 5'd31);
        add_item(bdq_pkg::OP_POP_FRONT, 32'sd0, 5'd0);
        add_item(bdq_pkg::OP_POP_BACK, 32'sd0, 5'd0);
        add_item(bdq_pkg::OP_INSERT, 32'sh5555_aaaa, 5'd2);
        add_item(bdq_pkg::OP_POP_FRONT, 32'sd0, 5'd0);
        add_item(bdq_pkg::OP_POP_FRONT, 32'sd0, 5'd0);

        // Sender mostly busy, receiver mostly idle
        add_random_bursts(RANDOM_ITEMS);
        wait_for_driver_idle();

        // Swap the idle pattern
        send_idle_pct = 63;
        recv_idle_pct = 9;
        bench_phase = 2;
        add_random_bursts(RANDOM_ITEMS);
        wait_for_driver_idle();

        // Full rate, with the long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bench_phase = 3;
        add_random_bursts(RANDOM_ITEMS);

        while (accepted_total != queued_total || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("[bounded_deque_with_insert] OK");
        else
            $display("[bounded_deque_with_insert] ERROR");
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #1000000;
        $display("[bounded_deque_with_insert] ERROR");
        $finish;
    end

endmodule
